// ===== src/grid_ghost_cell_boundary_fill_unit_defines.svh =====
// Assertion macros for the ghost-cell boundary fill unit.
// Used by the top level only; needs no other file.
`ifndef GRID_GHOST_CELL_BOUNDARY_FILL_UNIT_DEFINES_SVH
`define GRID_GHOST_CELL_BOUNDARY_FILL_UNIT_DEFINES_SVH

// Antecedent implies consequent in the same cycle.
`define GGCBF_ASSERT_IMP(label, clk, rstn, a, b) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (a) |-> (b)) \
        else $error("implication check failed");

// Antecedent implies consequent in the next cycle.
`define GGCBF_ASSERT_NXT(label, clk, rstn, a, b) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (a) |=> (b)) \
        else $error("next-cycle check failed");

`endif

// ===== src/ggcbf_pkg.sv =====
// Types, codes and helpers for the ghost-cell boundary fill unit.
// Standalone package; no dependencies.
`timescale 1ns / 1ps

package ggcbf_pkg;

    localparam int GRID_CELLS = 4096;
    localparam int ADDR_W     = $clog2(GRID_CELLS);
    localparam int SIZE_W     = 13;
    localparam int DEP_W      = 4;
    localparam int MAX_GHOST  = 8;
    localparam int VALUE_BITS = 32;
    localparam int CFG_IDX_W  = 4;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_READ  = 2'd1,
        OP_FILL  = 2'd2,
        OP_RSVD  = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_RANGE = 2'd1,
        STAT_BAD   = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        MODE_PERIODIC  = 2'd0,
        MODE_DIRICHLET = 2'd1,
        MODE_NEUMANN   = 2'd2,
        MODE_EXTRAP    = 2'd3
    } bc_mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NUM_DIMS    = 4'd0,
        CFG_SIZE_OUTER  = 4'd1,
        CFG_SIZE_MIDDLE = 4'd2,
        CFG_SIZE_INNER  = 4'd3,
        CFG_GHOST_DEPTH = 4'd4,
        CFG_MODE_OUTER  = 4'd5,
        CFG_MODE_MIDDLE = 4'd6,
        CFG_MODE_INNER  = 4'd7
    } cfg_index_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RDAT,
        S_FSETA,
        S_FSETB,
        S_FRD1,
        S_FRD2,
        S_FCALC,
        S_FWR,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [1:0]                   opcode;
        logic [11:0]                  cell_index;
        logic signed [VALUE_BITS-1:0] write_re;
        logic signed [VALUE_BITS-1:0] write_im;
        logic [1:0]                   axis;
        logic                         upper_side;
    } in_word_t;

    typedef struct packed {
        logic signed [VALUE_BITS-1:0] read_re;
        logic signed [VALUE_BITS-1:0] read_im;
        logic [1:0]                   status;
    } out_word_t;

    // 2*a - b, clipped to the signed value range
    function automatic logic signed [VALUE_BITS-1:0] extrap_sat(
        input logic signed [VALUE_BITS-1:0] a,
        input logic signed [VALUE_BITS-1:0] b
    );
        logic signed [VALUE_BITS+1:0] d;
        logic signed [VALUE_BITS+1:0] hi;
        logic signed [VALUE_BITS+1:0] lo;
        hi = {3'b000, {(VALUE_BITS-1){1'b1}}};
        lo = ~hi;
        d  = {a[VALUE_BITS-1], a, 1'b0} - {{2{b[VALUE_BITS-1]}}, b};
        if (d > hi) begin
            extrap_sat = hi[VALUE_BITS-1:0];
        end else if (d < lo) begin
            extrap_sat = lo[VALUE_BITS-1:0];
        end else begin
            extrap_sat = d[VALUE_BITS-1:0];
        end
    endfunction

endpackage

// ===== src/grid_ghost_cell_boundary_fill_unit.sv =====
// Ghost-cell boundary fill unit: grid store, read/write and fill sequencer.
// Depends on ggcbf_pkg and grid_ghost_cell_boundary_fill_unit_defines.svh.
//
//   channel | ports                          | word
//   input   | s_valid s_ready s_data         | in_word_t
//   result  | m_valid m_ready m_data         | out_word_t
//   config  | cfg_valid cfg_ready cfg_index  | cfg_data, 13 bits
//
// Writes and errors go straight to done; reads add a state for the registered read.
// A fill runs FSETA, FSETB, then per ghost line FRD1, FRD2, FCALC and an FWR per ghost
// cell, over the product of the other active dimensions' sizes, all on one memory port pair.
// After reset or any config write the input waits for the grid check to settle.
// A result not yet taken holds the unit in its done state, so the input waits.
`timescale 1ns / 1ps
`include "grid_ghost_cell_boundary_fill_unit_defines.svh"

module grid_ghost_cell_boundary_fill_unit
    import ggcbf_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  in_word_t             s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output out_word_t            m_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [SIZE_W-1:0]    cfg_data
);

    localparam logic [SIZE_W-1:0] ONE = SIZE_W'(1);

    // configuration
    logic [1:0]        num_dims_reg;
    logic [SIZE_W-1:0] size_reg [3];
    logic [DEP_W-1:0]  dep_reg;
    logic [1:0]        mode_reg [3];

    // grid check pipeline
    logic [2*SIZE_W-1:0] p01_reg;
    logic [SIZE_W-1:0]   s2e_reg;
    logic                zero_reg;
    logic                grid_ok_reg;
    logic [SIZE_W-1:0]   total_reg;
    logic [1:0]          settle_reg;

    // sequencer
    state_t state_reg, state_next;
    logic [1:0]        fmode_reg;
    logic              upper_reg;
    logic [1:0]        axis_reg;
    logic [SIZE_W-1:0] n_reg, below_reg, above_reg;
    logic [SIZE_W-1:0] off_a_reg, off_g_reg, line_reg;
    logic [SIZE_W-1:0] ibase_reg, k_reg, i_reg, a1_reg, gaddr_reg;
    logic [DEP_W-1:0]  p_reg;
    logic signed [VALUE_BITS-1:0] v1_reg, gval_reg;
    logic signed [VALUE_BITS-1:0] v1i_reg, gvali_reg;
    out_word_t res_reg;
    out_word_t m_data_reg;
    logic      m_valid_reg;

    // memory
    logic [2*VALUE_BITS-1:0] mem [GRID_CELLS];
    logic [2*VALUE_BITS-1:0] rdata_reg;
    logic                    mem_we;
    logic [ADDR_W-1:0]       mem_waddr, mem_raddr;
    logic [2*VALUE_BITS-1:0] mem_wdata;

    logic s_acc, cfg_acc, out_free, line_end, fill_end;

    assign cfg_ready = 1'b1;
    assign cfg_acc   = cfg_valid;
    assign s_acc     = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;
    assign line_end  = (p_reg == dep_reg - DEP_W'(1));
    assign fill_end  = line_end && (k_reg == below_reg - ONE) && (i_reg == above_reg - ONE);

    // accept-time decode
    logic [1:0]        a_mode;
    logic [SIZE_W-1:0] a_n;
    logic [DEP_W:0]    a_need;
    logic              a_fill_bad, a_fill_skip, a_range;
    always_comb begin
        a_mode      = mode_reg[s_data.axis];
        a_n         = size_reg[s_data.axis];
        a_need      = {1'b0, dep_reg} + {3'b000, a_mode} - (DEP_W+1)'(1);
        a_fill_bad  = ({1'b0, s_data.axis} >= {1'b0, num_dims_reg}) ||
                      (dep_reg > DEP_W'(MAX_GHOST)) ||
                      ((a_mode != MODE_PERIODIC) && (a_n < SIZE_W'(a_need)));
        a_fill_skip = (a_mode == MODE_PERIODIC) || (dep_reg == '0);
        a_range     = {1'b0, s_data.cell_index} >= total_reg;
    end

    // write configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_dims_reg <= 2'd1;
            size_reg[0]  <= SIZE_W'(16);
            size_reg[1]  <= ONE;
            size_reg[2]  <= ONE;
            dep_reg      <= DEP_W'(1);
            mode_reg[0]  <= MODE_PERIODIC;
            mode_reg[1]  <= MODE_PERIODIC;
            mode_reg[2]  <= MODE_PERIODIC;
        end else if (cfg_acc) begin
            case (cfg_index)
                CFG_NUM_DIMS:    num_dims_reg <= cfg_data[1:0];
                CFG_SIZE_OUTER:  size_reg[0]  <= cfg_data;
                CFG_SIZE_MIDDLE: size_reg[1]  <= cfg_data;
                CFG_SIZE_INNER:  size_reg[2]  <= cfg_data;
                CFG_GHOST_DEPTH: dep_reg      <= cfg_data[DEP_W-1:0];
                CFG_MODE_OUTER:  mode_reg[0]  <= cfg_data[1:0];
                CFG_MODE_MIDDLE: mode_reg[1]  <= cfg_data[1:0];
                CFG_MODE_INNER:  mode_reg[2]  <= cfg_data[1:0];
                default: ;
            endcase
        end
    end

    // grid size product, two registered multiplies
    logic [3*SIZE_W-1:0] prod_all;
    assign prod_all = p01_reg * s2e_reg;
    always_ff @(posedge aclk) begin
        p01_reg  <= size_reg[0] * ((num_dims_reg >= 2'd2) ? size_reg[1] : ONE);
        s2e_reg  <= (num_dims_reg >= 2'd3) ? size_reg[2] : ONE;
        zero_reg <= (num_dims_reg == 2'd0) || (size_reg[0] == '0) ||
                    ((num_dims_reg >= 2'd2) && (size_reg[1] == '0)) ||
                    ((num_dims_reg >= 2'd3) && (size_reg[2] == '0));
        grid_ok_reg <= !zero_reg && (prod_all <= (3*SIZE_W)'(GRID_CELLS));
        total_reg   <= prod_all[SIZE_W-1:0];
    end

    // hold input off until the product settles
    always_ff @(posedge aclk) begin
        if (!aresetn || cfg_acc) begin
            settle_reg <= 2'd3;
        end else if (settle_reg != 2'd0) begin
            settle_reg <= settle_reg - 2'd1;
        end
    end

    // grid store: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= mem[mem_raddr];
    end

    // advance state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_acc) begin
                    if (grid_ok_reg && s_data.opcode == OP_READ && !a_range) begin
                        state_next = S_RDAT;
                    end else if (grid_ok_reg && s_data.opcode == OP_FILL &&
                                 !a_fill_bad && !a_fill_skip) begin
                        state_next = S_FSETA;
                    end else begin
                        state_next = S_DONE;
                    end
                end
            end
            S_RDAT:  state_next = S_DONE;
            S_FSETA: state_next = S_FSETB;
            S_FSETB: state_next = S_FRD1;
            S_FRD1:  state_next = S_FRD2;
            S_FRD2:  state_next = S_FCALC;
            S_FCALC: state_next = S_FWR;
            S_FWR: begin
                if (fill_end) begin
                    state_next = S_DONE;
                end else if (line_end) begin
                    state_next = S_FRD1;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // handshake and memory port outputs
    always_comb begin
        s_ready   = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = s_data.cell_index;
        mem_wdata = {s_data.write_re, s_data.write_im};
        mem_raddr = s_data.cell_index;
        case (state_reg)
            S_IDLE: begin
                s_ready = (settle_reg == 2'd0);
                mem_we  = s_acc && grid_ok_reg && (s_data.opcode == OP_WRITE) && !a_range;
            end
            S_FRD1: mem_raddr = ADDR_W'(ibase_reg + k_reg + off_a_reg);
            S_FRD2: mem_raddr = ADDR_W'(upper_reg ? a1_reg - below_reg : a1_reg + below_reg);
            S_FWR: begin
                mem_we    = 1'b1;
                mem_waddr = ADDR_W'(gaddr_reg);
                mem_wdata = {gval_reg, gvali_reg};
            end
            default: ;
        endcase
    end

    // datapath registers of the sequencer
    logic [SIZE_W-1:0] below_c, above_c, offa_mul;
    always_comb begin
        case (axis_reg)
            2'd0: begin
                below_c = SIZE_W'(((num_dims_reg >= 2'd2) ? size_reg[1] : ONE) *
                                  ((num_dims_reg >= 2'd3) ? size_reg[2] : ONE));
                above_c = ONE;
            end
            2'd1: begin
                below_c = (num_dims_reg >= 2'd3) ? size_reg[2] : ONE;
                above_c = size_reg[0];
            end
            default: begin
                below_c = ONE;
                above_c = SIZE_W'(size_reg[0] * size_reg[1]);
            end
        endcase
        offa_mul = upper_reg ? n_reg - {{(SIZE_W-DEP_W){1'b0}}, dep_reg} - ONE
                             : {{(SIZE_W-DEP_W){1'b0}}, dep_reg};
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            S_IDLE: begin
                fmode_reg <= mode_reg[s_data.axis];
                upper_reg <= s_data.upper_side;
                axis_reg  <= s_data.axis;
                n_reg     <= a_n;
                res_reg.read_re <= '0;
                res_reg.read_im <= '0;
                if (!grid_ok_reg || s_data.opcode > OP_FILL) begin
                    res_reg.status <= STAT_BAD;
                end else if (s_data.opcode == OP_FILL) begin
                    res_reg.status <= a_fill_bad ? STAT_BAD : STAT_OK;
                end else begin
                    res_reg.status <= a_range ? STAT_RANGE : STAT_OK;
                end
            end
            S_RDAT: begin
                res_reg.read_re <= rdata_reg[2*VALUE_BITS-1:VALUE_BITS];
                res_reg.read_im <= rdata_reg[VALUE_BITS-1:0];
            end
            S_FSETA: begin
                below_reg <= below_c;
                above_reg <= above_c;
            end
            S_FSETB: begin
                off_a_reg <= SIZE_W'(offa_mul * below_reg);
                off_g_reg <= upper_reg ? SIZE_W'((n_reg - ONE) * below_reg) : '0;
                line_reg  <= SIZE_W'(n_reg * below_reg);
                ibase_reg <= '0;
                k_reg     <= '0;
                i_reg     <= '0;
            end
            S_FRD1: a1_reg <= ibase_reg + k_reg + off_a_reg;
            S_FRD2: v1_reg <= rdata_reg[2*VALUE_BITS-1:VALUE_BITS];
            S_FCALC: begin
                case (fmode_reg)
                    MODE_NEUMANN: gval_reg <= v1_reg;
                    MODE_EXTRAP:  gval_reg <= extrap_sat(v1_reg,
                                      rdata_reg[2*VALUE_BITS-1:VALUE_BITS]);
                    default:      gval_reg <= '0;
                endcase
                gaddr_reg <= ibase_reg + k_reg + off_g_reg;
                p_reg     <= '0;
            end
            S_FWR: begin
                p_reg     <= p_reg + DEP_W'(1);
                gaddr_reg <= upper_reg ? gaddr_reg - below_reg : gaddr_reg + below_reg;
                if (line_end) begin
                    if (k_reg == below_reg - ONE) begin
                        k_reg     <= '0;
                        ibase_reg <= ibase_reg + line_reg;
                        i_reg     <= i_reg + ONE;
                    end else begin
                        k_reg <= k_reg + ONE;
                    end
                end
            end
            default: ;
        endcase
    end

    // imaginary half: its own interior value and ghost value
    always_ff @(posedge aclk) begin
        case (state_reg)
            S_FRD2: v1i_reg <= rdata_reg[VALUE_BITS-1:0];
            S_FCALC: begin
                case (fmode_reg)
                    MODE_NEUMANN: gvali_reg <= v1i_reg;
                    MODE_EXTRAP:  gvali_reg <= extrap_sat(v1i_reg, rdata_reg[VALUE_BITS-1:0]);
                    default:      gvali_reg <= '0;
                endcase
            end
            default: ;
        endcase
    end

    // result register: load when the slot is free, drop on take
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (state_reg == S_DONE && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == S_DONE && out_free) begin
            m_data_reg <= res_reg;
        end
    end

    `GGCBF_ASSERT_NXT(a_leave_idle, aclk, aresetn, s_acc, state_reg != S_IDLE)
    `GGCBF_ASSERT_IMP(a_ghost_bound, aclk, aresetn, state_reg == S_FWR, p_reg < dep_reg)
    `GGCBF_ASSERT_NXT(a_cfg_settle, aclk, aresetn, cfg_acc, !s_ready)

endmodule
